@@ sv/ssgt_pkg.sv @@
// Shared types and constants for the step sequencer gate timer.
// No dependencies; compile first.
package ssgt_pkg;

  localparam int unsigned MAX_STEPS = 16;
  localparam int unsigned POS_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_STEPS + 1);

  localparam int unsigned NOW_W      = 16;
  localparam int unsigned ELAPSED_W  = 32;
  localparam int unsigned NOTE_W     = 8;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned STEP_IDX_W = 4;
  localparam int unsigned KNOB_W     = 10;
  localparam int unsigned LOGISH_W   = 11;
  localparam int unsigned PERIOD_W   = 15;
  localparam int unsigned GATE_W     = 15;

  localparam int unsigned LOGISH_KNEE = 800;
  localparam int unsigned LOGISH_GAIN = 2;
  localparam int unsigned PERIOD_BASE = 1000;
  localparam int unsigned PERIOD_SHL  = 3;
  localparam int unsigned PERIOD_SHR  = 8;
  localparam int unsigned NOTE_SHR    = 2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = KNOB_W;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LEN = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_ADD   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [NOW_W-1:0]  now;
    logic [NOTE_W-1:0] note_in;
    logic [TYPE_W-1:0] type_in;
  } in_word_t;

  typedef struct packed {
    logic                  running;
    logic                  gate;
    logic                  gate_rose;
    logic                  gate_fell;
    logic [STEP_IDX_W-1:0] step_index;
    logic [NOTE_W-1:0]     step_note;
    logic [TYPE_W-1:0]     step_type;
    logic                  add_accepted;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_word_t;

endpackage

@@ sv/ssgt_if.sv @@
// Valid/ready channel interfaces for input, result and configuration words.
// Depends on ssgt_pkg.
interface ssgt_in_if import ssgt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssgt_out_if import ssgt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssgt_cfg_if import ssgt_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/step_sequencer_gate_timer.sv @@
// Step sequencer with gate timer: step table, timer state and result register.
// Depends on ssgt_pkg and the channel interfaces in ssgt_if.sv.
//
// Usage:
//   in_i carries one word per operation: tick, start, stop or add step.
//   Every accepted word yields exactly one result word on out_o: running
//   flag, gate level and edges, current step index and its table entry,
//   and whether an add step was stored.
//   cfg_i writes the step length knob (index 0) and note length knob
//   (index 1); other indexes are ignored. cfg_i is always ready.
//   The result is registered: it appears in the cycle after its word is accepted.
//   Throughput: one word per cycle while out_o does not stall; all state
//   updates and the table read happen in one pass of logic between the
//   state registers and the result register.
//   When out_o stalls, the result register holds and in_i.ready drops
//   until the result is taken; a new word is taken in the same cycle
//   that the pending result leaves.
//   Reset clears the timer, position, step count, step table and knobs,
//   and empties the result register.
module step_sequencer_gate_timer
  import ssgt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ssgt_in_if.sink     in_i,
  ssgt_out_if.source  out_o,
  ssgt_cfg_if.sink    cfg_i
);

  logic [KNOB_W-1:0]    step_len_q, note_len_q;
  logic                 run_q, run_d;
  logic [NOW_W-1:0]     last_q, last_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                 gate_q, gate_d;
  logic                 prev_q, prev_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [NOTE_W-1:0]    note_tbl_q [MAX_STEPS];
  logic [TYPE_W-1:0]    type_tbl_q [MAX_STEPS];

  logic                 out_valid_q;
  out_word_t            out_q, out_d;

  logic                 in_fire, cfg_fire;
  logic                 wr_en;
  logic [POS_W-1:0]     wr_idx;
  logic [LOGISH_W-1:0]  logish;
  logic [PERIOD_W-1:0]  period;
  logic [GATE_W-1:0]    gate_len;
  logic [NOW_W-1:0]     delta;
  logic [ELAPSED_W-1:0] sum;
  logic [ELAPSED_W:0]   diff;
  logic [CNT_W-1:0]     pos_inc;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    if (step_len_q < KNOB_W'(LOGISH_KNEE)) begin
      logish = LOGISH_W'(step_len_q);
    end else begin
      logish = LOGISH_W'((step_len_q - KNOB_W'(LOGISH_KNEE)) << LOGISH_GAIN)
             + LOGISH_W'(LOGISH_KNEE);
    end
    period   = PERIOD_W'(PERIOD_BASE) + (PERIOD_W'(logish) << PERIOD_SHL);
    gate_len = GATE_W'(period[PERIOD_W-1:PERIOD_SHR])
             * GATE_W'(note_len_q[KNOB_W-1:NOTE_SHR]);
  end

  assign delta   = in_i.data.now - last_q;
  assign sum     = elapsed_q + ELAPSED_W'(delta);
  assign diff    = {1'b0, sum} - (ELAPSED_W + 1)'(period);
  assign pos_inc = CNT_W'(pos_q) + CNT_W'(1);

  always_comb begin
    run_d     = run_q;
    last_d    = last_q;
    elapsed_d = elapsed_q;
    gate_d    = gate_q;
    prev_d    = prev_q;
    count_d   = count_q;
    pos_d     = pos_q;
    wr_en     = 1'b0;
    wr_idx    = POS_W'(count_q);
    case (op_e'(in_i.data.operation))
      OP_TICK: begin
        if (run_q) begin
          last_d    = in_i.data.now;
          prev_d    = gate_q;
          elapsed_d = sum;
          if (!gate_q) begin
            if (!diff[ELAPSED_W]) begin
              elapsed_d = diff[ELAPSED_W-1:0];
              gate_d    = 1'b1;
              prev_d    = 1'b0;
              pos_d     = (pos_inc >= count_q) ? '0 : POS_W'(pos_inc);
            end
          end else if (sum >= ELAPSED_W'(gate_len)) begin
            gate_d = 1'b0;
            prev_d = 1'b1;
          end
        end
      end
      OP_START: begin
        run_d     = 1'b1;
        elapsed_d = '0;
        pos_d     = '0;
        last_d    = in_i.data.now;
        if (!gate_q) begin
          gate_d = 1'b1;
          prev_d = 1'b0;
        end
      end
      OP_STOP: begin
        run_d     = 1'b0;
        elapsed_d = '0;
        pos_d     = '0;
        if (gate_q) begin
          gate_d = 1'b0;
          prev_d = 1'b1;
        end
      end
      OP_ADD: begin
        if (count_q < CNT_W'(MAX_STEPS)) begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    out_d.running      = run_d;
    out_d.gate         = gate_d;
    out_d.gate_rose    = gate_d && !prev_d;
    out_d.gate_fell    = !gate_d && prev_d;
    out_d.step_index   = STEP_IDX_W'(pos_d);
    out_d.add_accepted = wr_en;
    if (wr_en && (wr_idx == pos_d)) begin
      out_d.step_note = in_i.data.note_in;
      out_d.step_type = in_i.data.type_in;
    end else begin
      out_d.step_note = note_tbl_q[pos_d];
      out_d.step_type = type_tbl_q[pos_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_len_q <= '0;
      note_len_q <= '0;
    end else if (cfg_fire) begin
      if (cfg_i.data.index == CFG_STEP_LEN) begin
        step_len_q <= cfg_i.data.data;
      end
      if (cfg_i.data.index == CFG_NOTE_LEN) begin
        note_len_q <= cfg_i.data.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      last_q    <= '0;
      elapsed_q <= '0;
      gate_q    <= 1'b0;
      prev_q    <= 1'b0;
      count_q   <= '0;
      pos_q     <= '0;
    end else if (in_fire) begin
      run_q     <= run_d;
      last_q    <= last_d;
      elapsed_q <= elapsed_d;
      gate_q    <= gate_d;
      prev_q    <= prev_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STEPS; i++) begin
        note_tbl_q[i] <= '0;
        type_tbl_q[i] <= '0;
      end
    end else if (in_fire && wr_en) begin
      note_tbl_q[wr_idx] <= in_i.data.note_in;
      type_tbl_q[wr_idx] <= in_i.data.type_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  a_pos_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(pos_q) < count_q) || (pos_q == '0))
    else $error("step position outside filled table");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.data.operation == OP_ADD) && (count_q < CNT_W'(MAX_STEPS)))
      |=> (count_q == $past(count_q) + CNT_W'(1)) && out_q.add_accepted)
    else $error("accepted add step did not grow the table");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.data.operation == OP_STOP))
      |=> !run_q && !gate_q && (pos_q == '0) && (elapsed_q == '0))
    else $error("stop left timer state behind");

  a_edges_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.gate_rose && out_q.gate_fell)
      && (!out_q.gate_rose || out_q.gate) && (!out_q.gate_fell || !out_q.gate))
    else $error("gate edge flags disagree with gate level");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_q.running == run_q) && (out_q.gate == gate_q)
      && (out_q.step_index == STEP_IDX_W'(pos_q)))
    else $error("result word does not match updated state");

endmodule
